FILE: src/mpqu_pkg.sv
// Shared types and codes for the unsorted-array max priority queue.
`default_nettype none

package mpqu_pkg;

    // Operation carried on the request side.
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Status codes carried with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int VALUE_W = 32;
    localparam int FILL_W  = 4;
    localparam int STATUS_W = 2;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

FILE: src/max_priority_queue_unsorted.sv
// Bounded max priority queue kept as an unsorted array in arrival order.
//
// Requests arrive on the s_axis channel: tuser holds the operation (enqueue
// or dequeue largest) and tdata the signed value to enqueue. Each request
// gives exactly one result on the m_axis channel with a status in tuser and
// the removed value and fill count in tdata.
// An enqueue or a request that hits a full or empty queue passes from the
// idle state to the final step, which loads the result register, and the
// sequencer then returns to idle for the next request. A dequeue passes
// through the scan and shift steps before the final step: the single read
// port of the entry memory is swept once for the maximum search, with one
// signed comparator, and then again from the position of the largest entry
// to close the gap, one entry a cycle.
// s_axis_tready is high only while the sequencer is idle; one request is in
// work at a time. A finished result waits in the output register while the
// receiver stalls, and the next request is still accepted meanwhile; the
// sequencer holds its final step until the output register is free.
// Reset empties the queue and clears the output valid; the entry memory
// itself is not cleared, since only written entries are ever read.
`default_nettype none

module max_priority_queue_unsorted
    import mpqu_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [VALUE_W-1:0]    s_axis_tdata,   // [31:0] value
    input  wire logic                  s_axis_tuser,   // [0] kind
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [31:0] result_value, [35:32] fill_count
    output logic [STATUS_W-1:0]        m_axis_tuser    // [1:0] status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               wr_en;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [VALUE_W-1:0] best_reg, best_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic               out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [STATUS_W-1:0] out_user_reg, out_user_next;

    logic               take;
    logic               scan_last;
    logic [AW-1:0]      shift_dest;
    logic               out_free;

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    // The shared comparator: the entry in the read register against the best so far.
    // Strictly greater keeps the oldest of equal maxima.
    assign take       = (idx_reg == '0) || ($signed(rd_data_reg) > $signed(best_reg));
    assign scan_last  = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign shift_dest = take ? idx_reg : best_idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        rd_addr        = idx_reg + AW'(1);
        wr_addr        = AW'(count_reg);
        wr_data        = s_axis_tdata;
        wr_en          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    best_next   = '0;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                    if (s_axis_tuser == KIND_ENQ)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (take)
                begin
                    best_next     = rd_data_reg;
                    best_idx_next = idx_reg;
                end
                if (scan_last)
                begin
                    // Prefetch the entry that moves into the freed slot.
                    rd_addr    = shift_dest + AW'(1);
                    idx_next   = shift_dest;
                    state_next = S_SHIFT;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_SHIFT:
            begin
                if ((CW'(idx_reg) + CW'(1)) < count_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg;
                    wr_data  = rd_data_reg;
                    rd_addr  = idx_reg + AW'(2);
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = status_reg;
                    out_data_next  = {4'b0000, FILL_W'(count_reg), best_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count exceeds capacity");

    // A new result appears only from the final step of the sequencer.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the final step");

    // The maximum search never starts or runs past the held entries.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CW'(idx_reg) < count_reg))
        else $error("scan index beyond held entries");

    // Closing the gap only happens on a non-empty queue.
    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (count_reg != '0))
        else $error("shift on an empty queue");

endmodule

`default_nettype wire
